[design/ipm_pkg.sv]
package ipm_pkg;

    localparam int MaxRulesDefault = 32;
    localparam int AddrW = 32;
    localparam int LenW = 6;
    localparam int IdW = 5;
    localparam int ClsW = 4;

    localparam logic [LenW-1:0] MaxLen = 6'd32;

    typedef enum logic [1:0] {
        KIND_ADDED = 2'd0,
        KIND_MATCH = 2'd1,
        KIND_NONE  = 2'd2,
        KIND_FULL  = 2'd3
    } kind_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic            load;
        logic            take;
        logic [ClsW-1:0] cls;
    } cell_ctl_t;

    // neighbor link: sel = an earlier cell is eligible, rest = pending cells left over
    typedef struct packed {
        logic sel;
        logic rest;
    } link_t;

    // a length above 32 shifts everything out, giving the full mask
    function automatic logic [AddrW-1:0] prefix_mask(input logic [LenW-1:0] len);
        prefix_mask = ~({AddrW{1'b1}} >> len);
    endfunction

    // output order: exact /0, partial 1-7, exact /8, partial 9-15, ... exact /32
    function automatic logic [ClsW-1:0] rule_class(input logic [LenW-1:0] len);
        rule_class = {len[5:3], |len[2:0]};
    endfunction

endpackage

[design/ipm_in_if.sv]
interface ipm_in_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [ipm_pkg::AddrW-1:0]    address;
    logic [ipm_pkg::LenW-1:0]     prefix_len;

    modport source (output valid, action, address, prefix_len, input ready);
    modport sink (input valid, action, address, prefix_len, output ready);
endinterface

[design/ipm_out_if.sv]
interface ipm_out_if;
    logic                      valid;
    logic                      ready;
    ipm_pkg::kind_t            result_kind;
    logic [ipm_pkg::IdW-1:0]   rule_id;
    logic                      last;

    modport source (output valid, result_kind, rule_id, last, input ready);
    modport sink (input valid, result_kind, rule_id, last, output ready);
endinterface

[design/ipv4_prefix_multi_match.sv]
// IPv4 prefix table with multi-match lookup. One rule per cell in a row of
// MAX_RULES cells. An add word is accepted, then written into the cell at the
// rule count once the output register is free, and answers with the new id,
// or table full. A match word is accepted, then every cell compares the query
// in parallel, then one result per cycle while the output register is free:
// the cells are swept class by class (exact /0, partial /1-7, exact /8, ...
// exact /32), the sweep moves on once the current class has no pending hit,
// and within a class the lowest id wins through the neighbor chain. The
// single output register stalls the sweep while the sink is not ready. A new
// word is taken once the previous one has put its last result into the
// output register.
module ipv4_prefix_multi_match #(
    parameter int MAX_RULES = ipm_pkg::MaxRulesDefault
) (
    input  logic       clk,
    input  logic       rst_n,
    ipm_in_if.sink     cmd,
    ipm_out_if.source  res
);

    localparam int CW = $clog2(MAX_RULES + 1);
    localparam int IDW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam logic [ipm_pkg::ClsW-1:0] LastCls = ipm_pkg::rule_class(ipm_pkg::MaxLen);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ADD  = 4'b0010,
        ST_LOAD = 4'b0100,
        ST_SCAN = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [ipm_pkg::ClsW-1:0] cls_reg, cls_next;
    logic [ipm_pkg::AddrW-1:0] addr_reg;
    logic [ipm_pkg::LenW-1:0] len_reg;

    logic ovalid_reg, ovalid_next;
    ipm_pkg::kind_t okind_reg;
    logic [ipm_pkg::IdW-1:0] oid_reg;
    logic olast_reg;

    logic emit;
    ipm_pkg::kind_t e_kind;
    logic [ipm_pkg::IdW-1:0] e_id;
    logic e_last;

    logic slot_free;
    logic full;
    logic accept;
    logic do_write;
    ipm_pkg::cell_ctl_t ctl;
    logic [ipm_pkg::AddrW-1:0] wr_network;

    ipm_pkg::link_t links [MAX_RULES+1];
    logic [IDW-1:0] ids [MAX_RULES+1];
    logic [MAX_RULES-1:0] grant_vec;

    assign slot_free = !ovalid_reg || res.ready;
    assign full = count_reg == CW'(MAX_RULES);
    assign cmd.ready = state_reg == ST_IDLE;
    assign accept = cmd.valid && cmd.ready;
    assign do_write = (state_reg == ST_ADD) && slot_free && !full;
    assign wr_network = addr_reg & ipm_pkg::prefix_mask(len_reg);

    assign links[0] = '0;
    assign ids[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_RULES; gi++)
        begin : g_cell
            ipm_cell #(
                .MAX_RULES(MAX_RULES),
                .CELL_IDX(gi)
            ) u_cell (
                .clk(clk),
                .rst_n(rst_n),
                .ctl(ctl),
                .wr(do_write && (count_reg == CW'(gi))),
                .wr_network(wr_network),
                .wr_length(len_reg),
                .query(addr_reg),
                .count(count_reg),
                .link_i(links[gi]),
                .link_o(links[gi+1]),
                .id_i(ids[gi]),
                .id_o(ids[gi+1]),
                .grant(grant_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cls_next = cls_reg;
        ctl = '0;
        ctl.cls = cls_reg;
        emit = 1'b0;
        e_kind = ipm_pkg::KIND_NONE;
        e_id = '0;
        e_last = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = cmd.action ? ST_LOAD : ST_ADD;
            end
            ST_ADD:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    if (full)
                        e_kind = ipm_pkg::KIND_FULL;
                    else
                    begin
                        e_kind = ipm_pkg::KIND_ADDED;
                        e_id = ipm_pkg::IdW'(count_reg);
                        count_next = count_reg + CW'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                ctl.load = 1'b1;
                cls_next = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (links[MAX_RULES].sel)
                begin
                    if (slot_free)
                    begin
                        emit = 1'b1;
                        ctl.take = 1'b1;
                        e_kind = ipm_pkg::KIND_MATCH;
                        e_id = ipm_pkg::IdW'(ids[MAX_RULES]);
                        e_last = !links[MAX_RULES].rest;
                        if (!links[MAX_RULES].rest)
                            state_next = ST_IDLE;
                    end
                end
                else if (links[MAX_RULES].rest)
                    cls_next = cls_reg + ipm_pkg::ClsW'(1);
                else if (slot_free)
                begin
                    // no rule covers the query
                    emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (emit)
            ovalid_next = 1'b1;
        else if (res.ready)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            cls_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cls_reg <= cls_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= cmd.address;
            len_reg <= (cmd.prefix_len > ipm_pkg::MaxLen) ? ipm_pkg::MaxLen : cmd.prefix_len;
        end
        if (emit)
        begin
            okind_reg <= e_kind;
            oid_reg <= e_id;
            olast_reg <= e_last;
        end
    end

    assign res.valid = ovalid_reg;
    assign res.result_kind = okind_reg;
    assign res.rule_id = oid_reg;
    assign res.last = olast_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_RULES))
        else $error("rule count above table size");

    a_grant_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(grant_vec))
        else $error("more than one cell granted");

    a_cls_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cls_reg <= LastCls))
        else $error("class sweep ran past the last class");

    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_write |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("rule count did not advance on add");

endmodule

[design/ipm_cell.sv]
module ipm_cell #(
    parameter int MAX_RULES = ipm_pkg::MaxRulesDefault,
    parameter int CELL_IDX = 0,
    localparam int CW = $clog2(MAX_RULES + 1),
    localparam int IDW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ipm_pkg::cell_ctl_t         ctl,
    input  logic                       wr,
    input  logic [ipm_pkg::AddrW-1:0]  wr_network,
    input  logic [ipm_pkg::LenW-1:0]   wr_length,
    input  logic [ipm_pkg::AddrW-1:0]  query,
    input  logic [CW-1:0]              count,
    input  ipm_pkg::link_t             link_i,
    output ipm_pkg::link_t             link_o,
    input  logic [IDW-1:0]             id_i,
    output logic [IDW-1:0]             id_o,
    output logic                       grant
);

    logic [ipm_pkg::AddrW-1:0] network_reg;
    logic [ipm_pkg::LenW-1:0]  length_reg;
    logic                      pending_reg;
    logic                      pending_next;
    logic                      active;
    logic                      hit;
    logic                      eligible;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            network_reg <= wr_network;
            length_reg  <= wr_length;
        end
    end

    assign active = count > CW'(CELL_IDX);
    assign hit = active &&
                 ((query & ipm_pkg::prefix_mask(length_reg)) == network_reg);
    assign eligible = pending_reg && (ipm_pkg::rule_class(length_reg) == ctl.cls);
    assign grant = eligible && !link_i.sel;

    assign link_o.sel  = link_i.sel | eligible;
    assign link_o.rest = link_i.rest | (pending_reg & !grant);
    assign id_o = id_i | (grant ? IDW'(CELL_IDX) : '0);

    always_comb
    begin
        pending_next = pending_reg;
        if (ctl.load)
            pending_next = hit;
        else if (ctl.take && grant)
            pending_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 1'b0;
        else
            pending_reg <= pending_next;
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int NumRules = 32;
    localparam int RandomWords = 412;
    localparam int DrainCycles = 40;
    localparam longint CycleLimit = 1000000;

    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_MATCH = 1'b1;

    typedef struct {
        ipm_pkg::kind_t             kind;
        logic [ipm_pkg::IdW-1:0]    id;
        logic                       last;
    } rule_result_t;

    function automatic logic [ipm_pkg::AddrW-1:0] net_mask(input int unsigned len);
        if (len == 0)
            return '0;
        if (len > 32)
            len = 32;
        return 32'hFFFF_FFFF << (32 - len);
    endfunction

    class prefix_scoreboard;
        logic [ipm_pkg::AddrW-1:0] nets[NumRules];
        int unsigned               lens[NumRules];
        int unsigned               count;
        rule_result_t              expected_q[$];
        int                        errors;

        function new();
            count = 0;
            errors = 0;
        endfunction

        function void push_result(ipm_pkg::kind_t kind, int unsigned id, logic last);
            rule_result_t r;
            r.kind = kind;
            r.id = id[ipm_pkg::IdW-1:0];
            r.last = last;
            expected_q.insert(expected_q.size(), r);
        endfunction

        // work out what one accepted word must produce and update the table
        function void note_word(logic act, logic [ipm_pkg::AddrW-1:0] addr,
                                logic [ipm_pkg::LenW-1:0] plen);
            int unsigned len;
            int          first;
            len = 32'(plen);
            if (act == ACT_ADD)
            begin
                if (len > 32)
                    len = 32;
                if (count >= NumRules)
                begin
                    push_result(ipm_pkg::KIND_FULL, 0, 1'b1);
                end
                else
                begin
                    nets[count] = addr & net_mask(len);
                    lens[count] = len;
                    push_result(ipm_pkg::KIND_ADDED, count, 1'b1);
                    count++;
                end
            end
            else
            begin
                first = expected_q.size();
                for (int d = 0; d <= 4; d++)
                begin
                    for (int i = 0; i < count; i++)
                        if (lens[i] == 8 * d && (addr & net_mask(lens[i])) == nets[i])
                            push_result(ipm_pkg::KIND_MATCH, i, 1'b0);
                    if (d < 4)
                    begin
                        // partial prefixes ending inside the next octet
                        for (int i = 0; i < count; i++)
                            if (lens[i] > 8 * d && lens[i] < 8 * d + 8 &&
                                (addr & net_mask(lens[i])) == nets[i])
                                push_result(ipm_pkg::KIND_MATCH, i, 1'b0);
                    end
                end
                if (expected_q.size() == first)
                    push_result(ipm_pkg::KIND_NONE, 0, 1'b1);
                else
                    expected_q[expected_q.size() - 1].last = 1'b1;
            end
        endfunction

        function void check_result(ipm_pkg::kind_t kind, logic [ipm_pkg::IdW-1:0] id,
                                   logic last);
            rule_result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d id %0d last %0d",
                         $time, kind, id, last);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (kind !== want.kind)
            begin
                $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, kind);
                errors++;
            end
            if (id !== want.id)
            begin
                $display("%0t: rule_id expected %0d actual %0d", $time, want.id, id);
                errors++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last expected %0d actual %0d", $time, want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    longint cycles;
    bit     cmd_calm;
    bit     res_calm;

    prefix_scoreboard sb;

    ipm_in_if  cmd();
    ipm_out_if res();

    ipv4_prefix_multi_match #(
        .MAX_RULES(NumRules)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .res(res)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
            sb.check_result(res.result_kind, res.rule_id, res.last);
    end

    // result side: random stall before every result, with calm stretches
    initial
    begin
        int unsigned stall;
        res.ready = 1'b0;
        res_calm = 1'b0;
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                res_calm = !res_calm;
            stall = res_calm ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                @(negedge clk);
                res.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            res.ready <= 1'b1;
            do @(posedge clk); while (!(res.valid && res.ready));
        end
    end

    task automatic send_word(input logic act, input logic [ipm_pkg::AddrW-1:0] addr,
                             input logic [ipm_pkg::LenW-1:0] plen);
        int unsigned gap;
        if ($urandom_range(0, 31) == 0)
            cmd_calm = !cmd_calm;
        gap = cmd_calm ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            @(negedge clk);
            cmd.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd.valid <= 1'b1;
        cmd.action <= act;
        cmd.address <= addr;
        cmd.prefix_len <= plen;
        do @(posedge clk); while (!cmd.ready);
        sb.note_word(act, addr, plen);
    endtask

    // an address inside a stored rule, low bits random
    function automatic logic [ipm_pkg::AddrW-1:0] covered_addr(output int unsigned idx);
        idx = $urandom_range(0, sb.count - 1);
        return sb.nets[idx] | ($urandom() & ~net_mask(sb.lens[idx]));
    endfunction

    initial
    begin
        int unsigned               k;
        int unsigned               idx;
        logic [ipm_pkg::AddrW-1:0] addr;
        logic [ipm_pkg::LenW-1:0]  plen;

        sb = new();
        cycles = 0;
        cmd_calm = 1'b0;
        rst_n = 1'b0;
        cmd.valid = 1'b0;
        cmd.action = ACT_ADD;
        cmd.address = '0;
        cmd.prefix_len = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty table, field extremes, saturated lengths, nested rules
        send_word(ACT_MATCH, 32'hFFFF_FFFF, 6'd63);
        send_word(ACT_ADD, 32'hFFFF_FFFF, 6'd0);
        send_word(ACT_ADD, 32'hFFFF_FFFF, 6'd32);
        send_word(ACT_ADD, 32'h0A0B_0C0D, 6'd40);
        send_word(ACT_ADD, 32'h0AFF_FFFF, 6'd8);
        send_word(ACT_ADD, 32'h0BFF_FFFF, 6'd7);
        send_word(ACT_ADD, 32'hC0A8_0000, 6'd1);
        send_word(ACT_ADD, 32'hFFFF_FFFE, 6'd31);
        send_word(ACT_ADD, 32'h1234_5678, 6'd63);
        send_word(ACT_ADD, 32'h0A0B_0000, 6'd16);
        send_word(ACT_ADD, 32'h0A0B_0C00, 6'd24);
        send_word(ACT_ADD, 32'h0A0B_0C80, 6'd25);
        send_word(ACT_MATCH, 32'hFFFF_FFFF, 6'd0);
        send_word(ACT_MATCH, 32'h0A0B_0C0D, 6'd32);
        send_word(ACT_MATCH, 32'h0000_0000, 6'd0);
        send_word(ACT_MATCH, 32'h0A0B_0CFF, 6'd0);
        send_word(ACT_MATCH, 32'h1234_5678, 6'd33);
        send_word(ACT_MATCH, 32'h7FFF_FFFF, 6'd31);

        for (int n = 0; n < RandomWords; n++)
        begin
            k = $urandom_range(0, 99);
            if (k < (sb.count < NumRules ? 30 : 6))
            begin
                k = $urandom_range(0, 99);
                if (sb.count > 0 && k < 45)
                begin
                    // nest under an existing rule so matches hit several rules
                    addr = covered_addr(idx);
                    plen = ipm_pkg::LenW'($urandom_range(sb.lens[idx], 32));
                end
                else
                begin
                    addr = $urandom();
                    if (k < 60)
                        plen = ipm_pkg::LenW'($urandom_range(33, 63));
                    else if (k < 75)
                        plen = ipm_pkg::LenW'(8 * $urandom_range(0, 4));
                    else
                        plen = ipm_pkg::LenW'($urandom_range(0, 32));
                end
                send_word(ACT_ADD, addr, plen);
            end
            else
            begin
                if (sb.count > 0 && $urandom_range(0, 99) < 75)
                    addr = covered_addr(idx);
                else
                    addr = $urandom();
                plen = ipm_pkg::LenW'($urandom_range(0, 63));
                send_word(ACT_MATCH, addr, plen);
            end
        end

        @(negedge clk);
        cmd.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
design/ipm_pkg.sv
design/ipm_in_if.sv
design/ipm_out_if.sv
design/ipm_cell.sv
design/ipv4_prefix_multi_match.sv
sim/testbench.sv
